/* rtl/assert_macros.svh */
// assertion helpers shared by the rtl files
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

`ifndef SYNTHESIS

// property must hold at every clock edge outside reset
`define GSR_ASSERT(lbl, prop, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (prop)) else $error(msg);

// expression must never be true outside reset
`define GSR_NEVER(lbl, expr, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) !(expr)) else $error(msg);

`else

`define GSR_ASSERT(lbl, prop, msg)
`define GSR_NEVER(lbl, expr, msg)

`endif

`endif

/* rtl/gsr_pkg.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// gsr_pkg
// shared constants and types of the grid shortest route search block
// ----------------------------------------------------------------------------
package gsr_pkg;

  localparam int GRID_ROWS = 16;
  localparam int GRID_COLS = 16;
  localparam int ROW_AW    = $clog2(GRID_ROWS);
  localparam int COL_AW    = $clog2(GRID_COLS);
  localparam int CNT_W     = $clog2(GRID_ROWS + 2);
  localparam int DIST_W    = 8;
  localparam int VF_W      = 2 * GRID_COLS;

  localparam logic REQ_LOAD  = 1'b0;
  localparam logic REQ_QUERY = 1'b1;

  typedef struct packed {
    logic       req_type;
    logic [3:0] row_index;
    logic [15:0] row_bits;
    logic [3:0] start_row;
    logic [3:0] start_col;
    logic [3:0] end_row;
    logic [3:0] end_col;
  } gsr_in_t;

  typedef struct packed {
    logic       reachable;
    logic [7:0] route_length;
  } gsr_out_t;

  // control from the sequencer to the wavefront datapath
  typedef struct packed {
    logic              start;
    logic              shift;
    logic              last_data;
    logic              compute;
    logic [ROW_AW-1:0] row;
  } gsr_wave_ctl_t;

  typedef struct packed {
    logic any;
    logic hit;
  } gsr_wave_stat_t;

endpackage

/* rtl/gsr_ram.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// gsr_ram
// generic simple dual port ram, one write and one registered read port
// ----------------------------------------------------------------------------
module gsr_ram #(
  parameter int WIDTH = 16,
  parameter int DEPTH = 16
) (
  input  logic                     clk_i,
  input  logic                     we_i,
  input  logic [$clog2(DEPTH)-1:0] waddr_i,
  input  logic [WIDTH-1:0]         wdata_i,
  input  logic [$clog2(DEPTH)-1:0] raddr_i,
  output logic [WIDTH-1:0]         rdata_o
);

  logic [WIDTH-1:0] mem_q [DEPTH];
  logic [WIDTH-1:0] rdata_q;

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
    rdata_q <= mem_q[raddr_i];
  end

  assign rdata_o = rdata_q;

endmodule

/* rtl/gsr_wave.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// gsr_wave
// three row window and next frontier logic of one wavefront sweep
// ----------------------------------------------------------------------------
`include "assert_macros.svh"

module gsr_wave (
  input  logic                            clk_i,
  input  logic                            rst_ni,
  input  gsr_pkg::gsr_wave_ctl_t         ctl_i,
  input  logic [gsr_pkg::VF_W-1:0]       vf_rdata_i,
  input  logic [gsr_pkg::GRID_COLS-1:0]  obs_rdata_i,
  input  logic [gsr_pkg::ROW_AW-1:0]     end_row_i,
  input  logic [gsr_pkg::COL_AW-1:0]     end_col_i,
  output logic [gsr_pkg::VF_W-1:0]       wr_data_o,
  output gsr_pkg::gsr_wave_stat_t        stat_o
);

  logic [gsr_pkg::GRID_COLS-1:0] prev_q, cur_q, obs_q, vis_q;
  logic [gsr_pkg::GRID_COLS-1:0] nxt, nbr, new_f;
  logic any_q, hit_q;

  // frontier of the row below the one being computed; zero past the grid
  assign nxt = ctl_i.last_data ? '0 : vf_rdata_i[gsr_pkg::GRID_COLS-1:0];

  assign nbr   = {cur_q[gsr_pkg::GRID_COLS-2:0], 1'b0} | {1'b0, cur_q[gsr_pkg::GRID_COLS-1:1]}
               | prev_q | nxt;
  assign new_f = nbr & ~obs_q & ~vis_q;

  assign wr_data_o = {vis_q | new_f, new_f};
  assign stat_o    = '{any: any_q, hit: hit_q};

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      any_q <= 1'b0;
      hit_q <= 1'b0;
    end else if (ctl_i.start) begin
      any_q <= 1'b0;
      hit_q <= 1'b0;
    end else if (ctl_i.compute) begin
      any_q <= any_q | (|new_f);
      hit_q <= hit_q | ((ctl_i.row == end_row_i) & new_f[end_col_i]);
    end
  end

  always_ff @(posedge clk_i) begin
    if (ctl_i.start) begin
      cur_q <= '0;
    end else if (ctl_i.shift) begin
      prev_q <= cur_q;
      cur_q  <= nxt;
      obs_q  <= obs_rdata_i;
      vis_q  <= ctl_i.last_data ? '0 : vf_rdata_i[gsr_pkg::VF_W-1:gsr_pkg::GRID_COLS];
    end
  end

  `GSR_ASSERT(a_hit_any, hit_q |-> any_q, "target hit without any frontier growth")
  `GSR_NEVER(a_start_compute, ctl_i.start && ctl_i.compute, "sweep start overlaps row write")
  `GSR_ASSERT(a_new_free, ctl_i.compute |-> ((new_f & obs_q) == '0), "frontier entered a blocked cell")

endmodule

/* rtl/grid_shortest_route_search_top.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// grid_shortest_route_search_top
// obstacle grid loader and breadth-first shortest route search
// ----------------------------------------------------------------------------
//  channel | signals                     | carries
//  in      | in_valid_i/in_ready_o       | gsr_in_t: row load or route query
//  out     | out_valid_o/out_ready_i     | gsr_out_t: one result per query
//
//  a row load is written as it is accepted; a query clears the route memory,
//  then sweeps one wavefront step per unit of route length, one row per cycle
//  through a single read port, and one step past the deepest wavefront when
//  unreachable; start on end is answered without clearing or sweeping
//  reset empties the obstacle grid through per-row valid bits, no clearing pass
//  a finished result waits in the output register; loads are still taken then
// ----------------------------------------------------------------------------
`include "assert_macros.svh"

module grid_shortest_route_search_top (
  input  logic             clk_i,
  input  logic             rst_ni,
  input  logic             in_valid_i,
  output logic             in_ready_o,
  input  gsr_pkg::gsr_in_t in_data_i,
  output logic             out_valid_o,
  input  logic             out_ready_i,
  output gsr_pkg::gsr_out_t out_data_o
);

  typedef enum logic [2:0] {
    ST_IDLE, ST_CLEAR, ST_SWEEP, ST_DECIDE, ST_RESULT
  } state_e;

  localparam int Rows = gsr_pkg::GRID_ROWS;
  localparam int Cols = gsr_pkg::GRID_COLS;

  state_e state_q, state_d;
  logic [gsr_pkg::CNT_W-1:0]  cnt_q, cnt_d;
  logic [gsr_pkg::DIST_W-1:0] dist_q, dist_d;
  logic [gsr_pkg::ROW_AW-1:0] sr_q, sr_d, er_q, er_d;
  logic [gsr_pkg::COL_AW-1:0] sc_q, sc_d, ec_q, ec_d;
  gsr_pkg::gsr_out_t res_q, res_d, out_q, out_d;
  logic out_valid_q, out_valid_d;
  logic [Rows-1:0] obs_vld_q;
  logic obs_rd_vld_q;

  logic in_acc, load_acc, query_acc, oob;
  logic [gsr_pkg::DIST_W:0] dist_inc;

  // memory ports
  logic obs_we, vf_we;
  logic [gsr_pkg::ROW_AW-1:0] obs_waddr, rd_addr, vf_waddr;
  logic [Cols-1:0] obs_wdata, obs_rdata_raw, obs_rdata, start_oh;
  logic [gsr_pkg::VF_W-1:0] vf_wdata, vf_rdata, wave_wdata;

  gsr_pkg::gsr_wave_ctl_t  wave_ctl;
  gsr_pkg::gsr_wave_stat_t wave_stat;

  assign in_ready_o = (state_q == ST_IDLE);
  assign in_acc     = in_valid_i & in_ready_o;
  assign load_acc   = in_acc & (in_data_i.req_type == gsr_pkg::REQ_LOAD);
  assign query_acc  = in_acc & (in_data_i.req_type == gsr_pkg::REQ_QUERY);

  // coordinates outside the grid give an unreachable answer
  assign oob = (int'(in_data_i.start_row) >= Rows) || (int'(in_data_i.start_col) >= Cols)
            || (int'(in_data_i.end_row) >= Rows) || (int'(in_data_i.end_col) >= Cols);

  // obstacle loads; rows outside the grid are dropped, excess column bits cut
  assign obs_we    = load_acc && (int'(in_data_i.row_index) < Rows);
  assign obs_waddr = gsr_pkg::ROW_AW'(in_data_i.row_index);
  assign obs_wdata = Cols'(in_data_i.row_bits);

  // one read address for both memories during a sweep, dummy read past the end
  assign rd_addr = (int'(cnt_q) < Rows) ? cnt_q[gsr_pkg::ROW_AW-1:0] : '0;

  gsr_ram #(.WIDTH(Cols), .DEPTH(Rows)) u_obs_ram (
    .clk_i   (clk_i),
    .we_i    (obs_we),
    .waddr_i (obs_waddr),
    .wdata_i (obs_wdata),
    .raddr_i (rd_addr),
    .rdata_o (obs_rdata_raw)
  );

  // a row never loaded since reset reads as free
  assign obs_rdata = obs_rd_vld_q ? obs_rdata_raw : '0;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      obs_vld_q    <= '0;
      obs_rd_vld_q <= 1'b0;
    end else begin
      if (obs_we) begin
        obs_vld_q[obs_waddr] <= 1'b1;
      end
      obs_rd_vld_q <= obs_vld_q[rd_addr];
    end
  end

  // visited in the upper half, frontier in the lower half
  assign start_oh = Cols'(1) << sc_q;
  assign vf_we    = (state_q == ST_CLEAR) || wave_ctl.compute;
  assign vf_waddr = (state_q == ST_CLEAR) ? cnt_q[gsr_pkg::ROW_AW-1:0] : wave_ctl.row;
  assign vf_wdata = (state_q == ST_CLEAR)
                  ? ((cnt_q[gsr_pkg::ROW_AW-1:0] == sr_q) ? {start_oh, start_oh} : '0)
                  : wave_wdata;

  gsr_ram #(.WIDTH(gsr_pkg::VF_W), .DEPTH(Rows)) u_vf_ram (
    .clk_i   (clk_i),
    .we_i    (vf_we),
    .waddr_i (vf_waddr),
    .wdata_i (vf_wdata),
    .raddr_i (rd_addr),
    .rdata_o (vf_rdata)
  );

  // sweep timing: row c is read at count c, read data comes back registered, row c-2 written at c
  logic [gsr_pkg::CNT_W-1:0] row_cnt;
  assign row_cnt = cnt_q - gsr_pkg::CNT_W'(2);

  always_comb begin
    wave_ctl.start     = (state_q == ST_SWEEP) && (cnt_q == '0);
    wave_ctl.shift     = (state_q == ST_SWEEP) && (cnt_q != '0);
    wave_ctl.last_data = (state_q == ST_SWEEP) && (cnt_q == gsr_pkg::CNT_W'(Rows + 1));
    wave_ctl.compute   = (state_q == ST_SWEEP) && (int'(cnt_q) >= 2);
    wave_ctl.row       = row_cnt[gsr_pkg::ROW_AW-1:0];
  end

  gsr_wave u_wave (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .ctl_i       (wave_ctl),
    .vf_rdata_i  (vf_rdata),
    .obs_rdata_i (obs_rdata),
    .end_row_i   (er_q),
    .end_col_i   (ec_q),
    .wr_data_o   (wave_wdata),
    .stat_o      (wave_stat)
  );

  // distance of the new frontier, saturating
  assign dist_inc = {1'b0, dist_q} + (gsr_pkg::DIST_W + 1)'(1);

  always_comb begin
    state_d     = state_q;
    cnt_d       = cnt_q;
    dist_d      = dist_q;
    sr_d        = sr_q;
    sc_d        = sc_q;
    er_d        = er_q;
    ec_d        = ec_q;
    res_d       = res_q;
    out_d       = out_q;
    out_valid_d = out_valid_q && !out_ready_i;
    case (state_q)
      ST_IDLE: begin
        if (query_acc) begin
          sr_d   = gsr_pkg::ROW_AW'(in_data_i.start_row);
          sc_d   = gsr_pkg::COL_AW'(in_data_i.start_col);
          er_d   = gsr_pkg::ROW_AW'(in_data_i.end_row);
          ec_d   = gsr_pkg::COL_AW'(in_data_i.end_col);
          cnt_d  = '0;
          dist_d = '0;
          if (oob) begin
            res_d   = '{reachable: 1'b0, route_length: '0};
            state_d = ST_RESULT;
          end else if ((in_data_i.start_row == in_data_i.end_row)
                       && (in_data_i.start_col == in_data_i.end_col)) begin
            res_d   = '{reachable: 1'b1, route_length: '0};
            state_d = ST_RESULT;
          end else begin
            state_d = ST_CLEAR;
          end
        end
      end
      ST_CLEAR: begin
        if (cnt_q == gsr_pkg::CNT_W'(Rows - 1)) begin
          cnt_d   = '0;
          state_d = ST_SWEEP;
        end else begin
          cnt_d = cnt_q + gsr_pkg::CNT_W'(1);
        end
      end
      ST_SWEEP: begin
        if (cnt_q == gsr_pkg::CNT_W'(Rows + 1)) begin
          state_d = ST_DECIDE;
        end else begin
          cnt_d = cnt_q + gsr_pkg::CNT_W'(1);
        end
      end
      ST_DECIDE: begin
        cnt_d = '0;
        if (wave_stat.hit) begin
          res_d.reachable    = 1'b1;
          res_d.route_length = dist_inc[gsr_pkg::DIST_W] ? '1 : dist_inc[gsr_pkg::DIST_W-1:0];
          state_d            = ST_RESULT;
        end else if (!wave_stat.any) begin
          res_d   = '{reachable: 1'b0, route_length: '0};
          state_d = ST_RESULT;
        end else begin
          dist_d  = dist_inc[gsr_pkg::DIST_W] ? '1 : dist_inc[gsr_pkg::DIST_W-1:0];
          state_d = ST_SWEEP;
        end
      end
      ST_RESULT: begin
        // hand over once the output register is free or being drained
        if (!out_valid_q || out_ready_i) begin
          out_d       = res_q;
          out_valid_d = 1'b1;
          state_d     = ST_IDLE;
        end
      end
      default: begin
        state_d = ST_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= ST_IDLE;
      cnt_q       <= '0;
      out_valid_q <= 1'b0;
    end else begin
      state_q     <= state_d;
      cnt_q       <= cnt_d;
      out_valid_q <= out_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    dist_q <= dist_d;
    sr_q   <= sr_d;
    sc_q   <= sc_d;
    er_q   <= er_d;
    ec_q   <= ec_d;
    res_q  <= res_d;
    out_q  <= out_d;
  end

  assign out_valid_o = out_valid_q;
  assign out_data_o  = out_q;

  `GSR_ASSERT(a_unreach_zero, (out_valid_q && !out_q.reachable) |-> (out_q.route_length == '0), "unreachable result with nonzero length")
  `GSR_ASSERT(a_vf_write_state, vf_we |-> ((state_q == ST_CLEAR) || (state_q == ST_SWEEP)), "route memory written outside a query")
  `GSR_ASSERT(a_result_drain, (state_q == ST_RESULT && (!out_valid_q || out_ready_i)) |=> (out_valid_q && state_q == ST_IDLE), "result not handed to the output register")

endmodule

/* sim/tb.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb
// self-checking bench for grid_shortest_route_search_top: row loads and route
// queries are driven through the input channel, each accepted query is solved
// by a bit-mask wavefront model of the grid, and results are compared in order
// ----------------------------------------------------------------------------
module tb;

  logic              clk_i;
  logic              rst_ni;
  logic              in_valid_i;
  logic              in_ready_o;
  gsr_pkg::gsr_in_t  in_data_i;
  logic              out_valid_o;
  logic              out_ready_i;
  gsr_pkg::gsr_out_t out_data_o;

  grid_shortest_route_search_top uut (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (in_valid_i),
    .in_ready_o  (in_ready_o),
    .in_data_i   (in_data_i),
    .out_valid_o (out_valid_o),
    .out_ready_i (out_ready_i),
    .out_data_o  (out_data_o)
  );

  // obstacle grid as the bench believes it is, and routes still owed
  logic [gsr_pkg::GRID_COLS-1:0] obstacle_map [gsr_pkg::GRID_ROWS];
  gsr_pkg::gsr_out_t             route_answers [$];

  int sender_idle_pct;
  int receiver_stall_pct;
  int hold_off_cycles;
  int mismatch_count;

  initial begin
    clk_i = 1'b0;
    forever #1 clk_i = ~clk_i;
  end

  // generous ceiling: every query at its slowest, with stalls on both sides
  initial begin
    #200_000_000;
    $display("[grid_shortest_route_search_top] ERROR");
    $finish;
  end

  // breadth-first wavefront over row masks; blocked start still expands,
  // blocked target is never entered
  function automatic gsr_pkg::gsr_out_t solve_route(input logic [3:0] sr,
                                                    input logic [3:0] sc,
                                                    input logic [3:0] er,
                                                    input logic [3:0] ec);
    logic [gsr_pkg::GRID_COLS-1:0] seen [gsr_pkg::GRID_ROWS];
    logic [gsr_pkg::GRID_COLS-1:0] front [gsr_pkg::GRID_ROWS];
    logic [gsr_pkg::GRID_COLS-1:0] grow [gsr_pkg::GRID_ROWS];
    gsr_pkg::gsr_out_t             res;
    int                            steps;
    bit                            spread;
    res = '0;
    steps = 0;
    for (int r = 0; r < gsr_pkg::GRID_ROWS; r++) begin
      seen[r] = '0;
      front[r] = '0;
    end
    front[sr][sc] = 1'b1;
    seen[sr][sc] = 1'b1;
    forever begin
      if (front[er][ec]) begin
        res.reachable = 1'b1;
        res.route_length = (steps > 255) ? 8'd255 : steps[7:0];
        return res;
      end
      spread = 1'b0;
      for (int r = 0; r < gsr_pkg::GRID_ROWS; r++) begin
        grow[r] = (front[r] << 1) | (front[r] >> 1);
        if (r > 0) grow[r] |= front[r-1];
        if (r < gsr_pkg::GRID_ROWS - 1) grow[r] |= front[r+1];
        grow[r] &= ~obstacle_map[r] & ~seen[r];
        if (grow[r] != '0) spread = 1'b1;
      end
      if (!spread) return res;
      for (int r = 0; r < gsr_pkg::GRID_ROWS; r++) begin
        front[r] = grow[r];
        seen[r] |= grow[r];
      end
      steps++;
    end
  endfunction

  // every accepted input transaction updates the grid or owes one answer
  always @(posedge clk_i) begin
    if (rst_ni && in_valid_i && in_ready_o) begin
      if (in_data_i.req_type == gsr_pkg::REQ_LOAD)
        obstacle_map[in_data_i.row_index] = in_data_i.row_bits;
      else
        route_answers.push_back(solve_route(in_data_i.start_row, in_data_i.start_col,
                                            in_data_i.end_row, in_data_i.end_col));
    end
  end

  // each output transaction against the oldest answer owed
  always @(posedge clk_i) begin
    gsr_pkg::gsr_out_t want;
    if (rst_ni && out_valid_o && out_ready_i) begin
      if (route_answers.size() == 0) begin
        mismatch_count++;
        if (mismatch_count <= 10)
          $display("unexpected result reach=%0d len=%0d",
                   out_data_o.reachable, out_data_o.route_length);
      end else begin
        want = route_answers.pop_front();
        if (out_data_o.reachable !== want.reachable ||
            out_data_o.route_length !== want.route_length) begin
          mismatch_count++;
          if (mismatch_count <= 10)
            $display("route mismatch: expected reach=%0d len=%0d, got reach=%0d len=%0d",
                     want.reachable, want.route_length,
                     out_data_o.reachable, out_data_o.route_length);
        end
      end
    end
  end

  // receiver: random stalls, plus a long hold-off on request so the block
  // fills its output register and refuses further queries
  always @(posedge clk_i) begin
    if (!rst_ni) begin
      out_ready_i <= 1'b0;
    end else if (hold_off_cycles > 0) begin
      hold_off_cycles <= hold_off_cycles - 1;
      out_ready_i <= 1'b0;
    end else begin
      out_ready_i <= ($urandom_range(99) >= receiver_stall_pct);
    end
  end

  task automatic send_item(input gsr_pkg::gsr_in_t item);
    int gap;
    if ($urandom_range(99) < sender_idle_pct) begin
      in_valid_i <= 1'b0;
      gap = $urandom_range(1, 6);
      repeat (gap) @(posedge clk_i);
    end
    in_valid_i <= 1'b1;
    in_data_i  <= item;
    do @(posedge clk_i); while (!in_ready_o);
  endtask

  task automatic send_load(input logic [3:0] row, input logic [15:0] bits);
    gsr_pkg::gsr_in_t item;
    item = gsr_pkg::gsr_in_t'({$urandom, $urandom});
    item.req_type  = gsr_pkg::REQ_LOAD;
    item.row_index = row;
    item.row_bits  = bits;
    send_item(item);
  endtask

  task automatic send_query(input logic [3:0] sr, input logic [3:0] sc,
                            input logic [3:0] er, input logic [3:0] ec);
    gsr_pkg::gsr_in_t item;
    item = gsr_pkg::gsr_in_t'({$urandom, $urandom});
    item.req_type  = gsr_pkg::REQ_QUERY;
    item.start_row = sr;
    item.start_col = sc;
    item.end_row   = er;
    item.end_col   = ec;
    send_item(item);
  endtask

  // corners, start on end, blocked start and target, walls, a long snake
  task automatic test_directed();
    send_query(4'd0, 4'd0, 4'd15, 4'd15);
    send_query(4'd15, 4'd15, 4'd0, 4'd0);
    send_query(4'd7, 4'd9, 4'd7, 4'd9);
    send_load(4'd5, 16'hffff);
    send_query(4'd0, 4'd0, 4'd15, 4'd0);
    send_query(4'd5, 4'd3, 4'd6, 4'd3);
    send_query(4'd5, 4'd8, 4'd5, 4'd8);
    send_query(4'd0, 4'd0, 4'd5, 4'd7);
    // snake: every odd row walled except one gap at alternating ends
    for (int r = 1; r < gsr_pkg::GRID_ROWS; r += 2)
      send_load(r[3:0], (r % 4 == 1) ? 16'h7fff : 16'hfffe);
    send_query(4'd0, 4'd0, 4'd14, 4'd0);
    send_query(4'd14, 4'd15, 4'd0, 4'd0);
  endtask

  function automatic logic [15:0] random_row();
    case ($urandom_range(3))
      0:       return 16'($urandom & $urandom & $urandom);
      1:       return 16'($urandom & $urandom);
      2:       return 16'($urandom);
      default: return 16'h0000;
    endcase
  endfunction

  // rounds of up to four row loads followed by one to four queries, unused fields random
  task automatic test_random(input int count, input int idle_pct, input int stall_pct,
                             input bit squeeze);
    int sent;
    int n;
    bit squeezed;
    sender_idle_pct    = idle_pct;
    receiver_stall_pct = stall_pct;
    sent = 0;
    squeezed = 1'b0;
    while (sent < count) begin
      if (squeeze && !squeezed && sent >= count / 2) begin
        hold_off_cycles = 800;
        squeezed = 1'b1;
      end
      n = $urandom_range(0, 4);
      for (int i = 0; i < n; i++) begin
        send_load(4'($urandom_range(15)), random_row());
        sent++;
      end
      n = $urandom_range(1, 4);
      for (int i = 0; i < n; i++) begin
        send_query(4'($urandom_range(15)), 4'($urandom_range(15)),
                   4'($urandom_range(15)), 4'($urandom_range(15)));
        sent++;
      end
    end
  endtask

  initial begin
    in_valid_i         = 1'b0;
    in_data_i          = '0;
    sender_idle_pct    = 0;
    receiver_stall_pct = 0;
    hold_off_cycles    = 0;
    mismatch_count     = 0;
    for (int r = 0; r < gsr_pkg::GRID_ROWS; r++) obstacle_map[r] = '0;
    rst_ni = 1'b0;
    repeat (4) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    test_directed();
    test_random(480, 0, 0, 1'b1);
    test_random(480, 77, 0, 1'b0);
    test_random(480, 0, 77, 1'b0);
    test_random(480, 9, 9, 1'b0);
    in_valid_i <= 1'b0;

    wait (route_answers.size() == 0);
    repeat (100) @(posedge clk_i);
    if (mismatch_count == 0 && route_answers.size() == 0)
      $display("[grid_shortest_route_search_top] OK");
    else
      $display("[grid_shortest_route_search_top] ERROR");
    $finish;
  end

endmodule
